/* rtl/core/prt_pkg.sv */
// ============================================================================
// prt_pkg
// Shared widths, command codes and control types for the pending request table.
// ============================================================================
`default_nettype none

package prt_pkg;

    localparam int CMD_W    = 2;
    localparam int KEY_IN_W = 32;
    localparam int ID_W     = 8;
    localparam int TIME_W   = 32;

    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FIND   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_ATTACH = 2'd3;

    // ids run 1..ID_LIMIT-1, zero means none
    localparam logic [ID_W:0]   ID_LIMIT = 9'd255;
    localparam logic [ID_W-1:0] ID_NONE  = 8'd0;
    localparam logic [ID_W-1:0] ID_FIRST = 8'd1;

    typedef struct packed {
        logic            by_key;
        logic [ID_W-1:0] id;
    } t_cmp_ctl;

endpackage

`default_nettype wire

/* rtl/core/prt_if.sv */
// ============================================================================
// prt_if
// Request and response channels of the pending request table.
// ============================================================================
`default_nettype none

interface prt_req_if import prt_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [KEY_IN_W-1:0] name_key;
    logic [ID_W-1:0]     request_id;
    logic [ID_W-1:0]     forward_id;
    logic [TIME_W-1:0]   now_ms;

    modport source (output valid, cmd, name_key, request_id, forward_id, now_ms,
                    input ready);
    modport sink   (input valid, cmd, name_key, request_id, forward_id, now_ms,
                    output ready);
endinterface

interface prt_rsp_if import prt_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [ID_W-1:0] result_id;
    logic            success;

    modport source (output valid, result_id, success, input ready);
    modport sink   (input valid, result_id, success, output ready);
endinterface

`default_nettype wire

/* rtl/core/prt_ram.sv */
// ============================================================================
// prt_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`default_nettype none

module prt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                                  i_clk,
    input  wire                                  i_wr_en,
    input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire [WIDTH-1:0]                      i_wr_data,
    input  wire                                  i_rd_en,
    input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                     o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/prt_cmp.sv */
// ============================================================================
// prt_cmp
// Shared match unit: compares one table entry against the key or the id.
// ============================================================================
`default_nettype none

module prt_cmp import prt_pkg::*; #(
    parameter int KEY_W = 32
) (
    input  wire t_cmp_ctl    i_ctl,
    input  wire [KEY_W-1:0]  i_key,
    input  wire [KEY_W-1:0]  i_entry_key,
    input  wire [ID_W-1:0]   i_entry_id,
    output logic             o_match
);

    always_comb begin
        if (i_ctl.by_key) begin
            o_match = (i_entry_key == i_key);
        end else begin
            o_match = (i_ctl.id != ID_NONE) && (i_entry_id == i_ctl.id);
        end
    end

endmodule

`default_nettype wire

/* rtl/core/pending_request_table.sv */
// ============================================================================
// pending_request_table
// Packed table of pending requests: add, remove by id, find by key, attach.
// ============================================================================
// Usage:
//   i_req carries one command per transaction (cmd, name_key, request_id,
//   forward_id, now_ms); o_rsp returns exactly one transaction per command
//   with result_id and success.
//   Entries live packed in one RAM in insertion order. A command scans them
//   one per cycle through the shared match unit; a remove then moves each
//   later entry down one slot per cycle.
//   After acceptance the sequencer passes through S_SCAN (entered even when
//   the table is empty), S_SHIFT for a remove that moves entries, and S_DONE,
//   which loads o_rsp once the output register is free. The single RAM read
//   port paces the scan and the move. The next command is taken the cycle
//   after the response loads.
//   i_req.ready is high only while the sequencer is idle, one command at a
//   time. A finished response waits in the output register, so the next
//   command is taken while o_rsp is stalled; the sequencer holds its
//   following response until the output register frees.
//   Reset empties the table and restarts ids at 1; no clearing pass.
// ============================================================================
`default_nettype none

module pending_request_table import prt_pkg::*; #(
    parameter int TABLE_DEPTH = 16,
    parameter int KEY_BITS    = 32
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    prt_req_if.sink    i_req,
    prt_rsp_if.source  o_rsp
);

    localparam int KW = (KEY_BITS < KEY_IN_W) ? KEY_BITS : KEY_IN_W;
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int EW = KW + 2 * ID_W + TIME_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]        r_state,   n_state;
    logic [CW-1:0]     r_count,   n_count;
    logic [ID_W-1:0]   r_last_id, n_last_id;
    logic [IW-1:0]     r_idx,     n_idx;
    logic [CMD_W-1:0]  r_cmd,     n_cmd;
    logic [KW-1:0]     r_key,     n_key;
    logic [ID_W-1:0]   r_rid,     n_rid;
    logic [ID_W-1:0]   r_fwd,     n_fwd;
    logic [TIME_W-1:0] r_now,     n_now;
    logic [ID_W-1:0]   r_res,     n_res;
    logic              r_ok,      n_ok;
    logic              r_out_valid, n_out_valid;
    logic [ID_W-1:0]   r_out_id,    n_out_id;
    logic              r_out_ok,    n_out_ok;

    logic          ram_we, ram_re;
    logic [IW-1:0] ram_waddr, ram_raddr;
    logic [EW-1:0] ram_wdata, ram_rdata;

    logic [KW-1:0]     rd_key;
    logic [ID_W-1:0]   rd_id;
    logic [TIME_W-1:0] rd_time;

    t_cmp_ctl        cmp_ctl;
    logic            cmp_match;
    logic            hit, last;
    logic [ID_W:0]   id_sum;
    logic [ID_W-1:0] id_new;
    logic [CW-1:0]   count_m1;
    logic            out_free;

    assign rd_key  = ram_rdata[EW-1 -: KW];
    assign rd_id   = ram_rdata[2*ID_W+TIME_W-1 -: ID_W];
    assign rd_time = ram_rdata[TIME_W-1:0];

    assign cmp_ctl = '{by_key: (r_cmd == CMD_ADD) || (r_cmd == CMD_FIND), id: r_rid};

    prt_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_en   (ram_re),
        .i_rd_addr (ram_raddr),
        .o_rd_data (ram_rdata)
    );

    prt_cmp #(
        .KEY_W (KW)
    ) u_cmp (
        .i_ctl       (cmp_ctl),
        .i_key       (r_key),
        .i_entry_key (rd_key),
        .i_entry_id  (rd_id),
        .o_match     (cmp_match)
    );

    assign hit      = (r_count != '0) && cmp_match;
    assign last     = (CW'(r_idx) + CW'(1)) >= r_count;
    assign count_m1 = r_count - CW'(1);
    assign id_sum   = {1'b0, r_last_id} + {{ID_W{1'b0}}, 1'b1};
    assign id_new   = (id_sum >= ID_LIMIT) ? ID_FIRST : id_sum[ID_W-1:0];
    assign out_free = !r_out_valid || o_rsp.ready;

    assign i_req.ready     = (r_state == S_IDLE);
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.result_id = r_out_id;
    assign o_rsp.success   = r_out_ok;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_last_id   = r_last_id;
        n_idx       = r_idx;
        n_cmd       = r_cmd;
        n_key       = r_key;
        n_rid       = r_rid;
        n_fwd       = r_fwd;
        n_now       = r_now;
        n_res       = r_res;
        n_ok        = r_ok;
        n_out_valid = r_out_valid;
        n_out_id    = r_out_id;
        n_out_ok    = r_out_ok;
        ram_we      = 1'b0;
        ram_waddr   = r_idx;
        ram_wdata   = ram_rdata;
        ram_re      = 1'b0;
        ram_raddr   = r_idx;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_cmd   = i_req.cmd;
                    n_key   = i_req.name_key[KW-1:0];
                    n_rid   = i_req.request_id;
                    n_fwd   = i_req.forward_id;
                    n_now   = i_req.now_ms;
                    n_res   = ID_NONE;
                    n_ok    = 1'b0;
                    n_idx   = '0;
                    ram_re  = 1'b1;
                    ram_raddr = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (hit) begin
                    n_state = S_DONE;
                    case (r_cmd)
                        CMD_FIND: begin
                            n_res = rd_id;
                            n_ok  = 1'b1;
                        end
                        CMD_ATTACH: begin
                            ram_we    = 1'b1;
                            ram_waddr = r_idx;
                            ram_wdata = {rd_key, rd_id, r_fwd, rd_time};
                            n_ok      = 1'b1;
                        end
                        CMD_REMOVE: begin
                            n_ok    = 1'b1;
                            n_count = count_m1;
                            if (CW'(r_idx) < count_m1) begin
                                ram_re    = 1'b1;
                                ram_raddr = r_idx + IW'(1);
                                n_idx     = r_idx + IW'(1);
                                n_state   = S_SHIFT;
                            end
                        end
                        default: begin
                            // duplicate key on add
                            n_ok = 1'b0;
                        end
                    endcase
                end else if (!last) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_idx + IW'(1);
                    n_idx     = r_idx + IW'(1);
                end else begin
                    n_state = S_DONE;
                    if (r_cmd == CMD_ADD && r_count < CW'(TABLE_DEPTH)) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_count[IW-1:0];
                        ram_wdata = {r_key, id_new, ID_NONE, r_now};
                        n_count   = r_count + CW'(1);
                        n_last_id = id_new;
                        n_res     = id_new;
                        n_ok      = 1'b1;
                    end
                end
            end
            S_SHIFT: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx - IW'(1);
                ram_wdata = ram_rdata;
                if (CW'(r_idx) < r_count) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_idx + IW'(1);
                    n_idx     = r_idx + IW'(1);
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_id    = r_res;
                    n_out_ok    = r_ok;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_last_id   <= ID_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_last_id   <= n_last_id;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_cmd    <= n_cmd;
        r_key    <= n_key;
        r_rid    <= n_rid;
        r_fwd    <= n_fwd;
        r_now    <= n_now;
        r_res    <= n_res;
        r_ok     <= n_ok;
        r_out_id <= n_out_id;
        r_out_ok <= n_out_ok;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_id_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_last_id != ID_LIMIT[ID_W-1:0])
        else $error("id counter reached reserved value");

    a_rsp_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_DONE)
        else $error("response raised outside completion");

    a_id_means_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_id != ID_NONE) |-> r_out_ok)
        else $error("nonzero id reported without success");

endmodule

`default_nettype wire
